FILE: hdl/pn_pkg.sv
package pn_pkg;

    localparam int PATH_CAPACITY_DEF = 64;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [1:0] ACT_ROOT = 2'd0;
    localparam logic [1:0] ACT_BYTE = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       out_empty;
    } t_result;

endpackage

FILE: hdl/path_normalizer.sv
// Root and ignored actions are handled in S_IDLE alone; a path byte passes through S_PUT as well
// when it opens a new component. A terminator closing a ".." component walks back through the path
// store port, one byte at a time through S_UP_CHK and S_UP_WAIT. A read out passes each path byte
// through S_RD_ADDR (address) and S_RD_DATA (registered store data); an empty path gives a single
// empty result. Results are registered in the output stage and can wait there while input resumes.
// Reset is synchronous and active low; it returns the path to root with no sweep.
module path_normalizer #(
    parameter int PATH_CAPACITY = pn_pkg::PATH_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // path_byte[7:0]
    input  logic [1:0] s_axis_tuser,   // action[1:0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_char[7:0]
    output logic       m_axis_tlast,
    output logic [0:0] m_axis_tuser    // out_empty[0]
);

    localparam int AW = $clog2(PATH_CAPACITY);
    localparam int LW = $clog2(PATH_CAPACITY + 1);

    logic            out_free;
    logic            push;
    pn_pkg::t_result result;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [AW-1:0]   raddr;
    logic [7:0]      rdata;

    logic            r_m_valid;
    pn_pkg::t_result r_m_data;

    pn_store #(
        .DEPTH (PATH_CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pn_core #(
        .PATH_CAPACITY (PATH_CAPACITY),
        .AW            (AW),
        .LW            (LW)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_byte     (s_axis_tdata),
        .i_out_free (out_free),
        .o_push     (push),
        .o_result   (result),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (push) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_m_data <= result;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data.out_char;
    assign m_axis_tlast    = r_m_data.out_last;
    assign m_axis_tuser[0] = r_m_data.out_empty;

endmodule

FILE: hdl/pn_store.sv
module pn_store #(
    parameter int DEPTH = pn_pkg::PATH_CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;
    logic       r_zero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // A read of entry zero always returns the root slash.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q    <= r_mem[i_raddr];
            r_zero <= (i_raddr == '0);
        end
    end

    assign o_rdata = r_zero ? pn_pkg::CHAR_SLASH : r_q;

endmodule

FILE: hdl/pn_core.sv
module pn_core #(
    parameter int PATH_CAPACITY = pn_pkg::PATH_CAPACITY_DEF,
    parameter int AW            = $clog2(PATH_CAPACITY),
    parameter int LW            = $clog2(PATH_CAPACITY + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_byte,
    input  logic             i_out_free,
    output logic             o_push,
    output pn_pkg::t_result  o_result,
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output logic [7:0]       o_wdata,
    output logic             o_re,
    output logic [AW-1:0]    o_raddr,
    input  logic [7:0]       i_rdata
);

    localparam logic [LW-1:0] CapLen = LW'(PATH_CAPACITY);
    localparam logic [LW-1:0] OneLen = LW'(1);
    localparam logic [LW-1:0] TwoLen = LW'(2);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_PUT     = 6'b000010,
        S_UP_CHK  = 6'b000100,
        S_UP_WAIT = 6'b001000,
        S_RD_ADDR = 6'b010000,
        S_RD_DATA = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic          r_tail, n_tail;
    logic [LW-1:0] r_cstart, n_cstart;
    logic          r_stail, n_stail;
    logic [1:0]    r_count, n_count;
    logic          r_dots, n_dots;
    logic          r_at_start, n_at_start;
    logic          r_phase, n_phase;
    logic [7:0]    r_byte, n_byte;
    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_rlen, n_rlen;

    logic       accept;
    logic       put_en;
    logic [7:0] put_char;
    logic       put_ok;
    logic       rd_last;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign rd_last = ((r_idx + OneLen) == r_rlen);

    always_comb begin
        if (r_state == S_PUT) begin
            put_char = r_byte;
        end else if (r_count == 2'd0) begin
            put_char = pn_pkg::CHAR_SLASH;
        end else begin
            put_char = i_byte;
        end
        put_ok = (r_len < CapLen) &&
                 !((put_char == pn_pkg::CHAR_SLASH) && (r_len != '0) && r_tail);
    end

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_tail     = r_tail;
        n_cstart   = r_cstart;
        n_stail    = r_stail;
        n_count    = r_count;
        n_dots     = r_dots;
        n_at_start = r_at_start;
        n_phase    = r_phase;
        n_byte     = r_byte;
        n_idx      = r_idx;
        n_rlen     = r_rlen;
        put_en     = 1'b0;
        o_push     = 1'b0;
        o_result   = '0;
        o_re       = 1'b0;
        o_raddr    = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        pn_pkg::ACT_ROOT: begin
                            n_len      = OneLen;
                            n_tail     = 1'b1;
                            n_cstart   = OneLen;
                            n_stail    = 1'b1;
                            n_count    = 2'd0;
                            n_dots     = 1'b1;
                            n_at_start = 1'b1;
                        end
                        pn_pkg::ACT_BYTE: begin
                            n_at_start = 1'b0;
                            if (r_at_start && (i_byte == pn_pkg::CHAR_SLASH)) begin
                                n_len    = OneLen;
                                n_tail   = 1'b1;
                                n_cstart = OneLen;
                                n_stail  = 1'b1;
                                n_count  = 2'd0;
                                n_dots   = 1'b1;
                            end else if ((i_byte == pn_pkg::CHAR_SLASH) ||
                                         (i_byte == pn_pkg::CHAR_NUL)) begin
                                if (r_dots && (r_count == 2'd2)) begin
                                    n_len   = r_cstart;
                                    n_tail  = r_stail;
                                    n_phase = 1'b0;
                                    n_state = S_UP_CHK;
                                end else if (r_dots && (r_count == 2'd1)) begin
                                    n_len  = r_cstart;
                                    n_tail = r_stail;
                                end else begin
                                    n_cstart = r_len;
                                    n_stail  = r_tail;
                                end
                                n_count = 2'd0;
                                n_dots  = 1'b1;
                                if (i_byte == pn_pkg::CHAR_NUL) begin
                                    n_at_start = 1'b1;
                                end
                            end else begin
                                put_en = 1'b1;
                                if (r_count == 2'd0) begin
                                    n_cstart = r_len;
                                    n_stail  = r_tail;
                                    n_byte   = i_byte;
                                    n_state  = S_PUT;
                                end
                                if (r_count != 2'd3) begin
                                    n_count = r_count + 2'd1;
                                end
                                if (i_byte != pn_pkg::CHAR_DOT) begin
                                    n_dots = 1'b0;
                                end
                            end
                        end
                        pn_pkg::ACT_READ: begin
                            n_rlen  = (r_count != 2'd0) ? r_cstart : r_len;
                            n_idx   = '0;
                            n_state = S_RD_ADDR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PUT: begin
                put_en  = 1'b1;
                n_state = S_IDLE;
            end
            S_UP_CHK: begin
                if ((r_len == '0) || (r_phase && r_tail)) begin
                    n_cstart = r_len;
                    n_stail  = r_tail;
                    n_state  = S_IDLE;
                end else begin
                    if (!r_tail) begin
                        n_phase = 1'b1;
                    end
                    n_len = r_len - OneLen;
                    if (r_len >= TwoLen) begin
                        o_re    = 1'b1;
                        o_raddr = AW'(r_len - TwoLen);
                        n_state = S_UP_WAIT;
                    end
                end
            end
            S_UP_WAIT: begin
                n_tail  = (i_rdata == pn_pkg::CHAR_SLASH);
                n_state = S_UP_CHK;
            end
            S_RD_ADDR: begin
                if (r_rlen == '0) begin
                    if (i_out_free) begin
                        o_push             = 1'b1;
                        o_result.out_last  = 1'b1;
                        o_result.out_empty = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_idx[AW-1:0];
                    n_state = S_RD_DATA;
                end
            end
            S_RD_DATA: begin
                if (i_out_free) begin
                    o_push            = 1'b1;
                    o_result.out_char = i_rdata;
                    o_result.out_last = rd_last;
                    if (rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + OneLen;
                        n_state = S_RD_ADDR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (put_en && put_ok) begin
            n_len  = r_len + OneLen;
            n_tail = (put_char == pn_pkg::CHAR_SLASH);
        end
    end

    assign o_we    = put_en && put_ok;
    assign o_waddr = r_len[AW-1:0];
    assign o_wdata = put_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= OneLen;
            r_tail     <= 1'b1;
            r_cstart   <= OneLen;
            r_stail    <= 1'b1;
            r_count    <= 2'd0;
            r_dots     <= 1'b1;
            r_at_start <= 1'b1;
            r_phase    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_tail     <= n_tail;
            r_cstart   <= n_cstart;
            r_stail    <= n_stail;
            r_count    <= n_count;
            r_dots     <= n_dots;
            r_at_start <= n_at_start;
            r_phase    <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_idx  <= n_idx;
        r_rlen <= n_rlen;
    end

endmodule
